[src/frd_pkg.sv]
// shared constants, word types and interface structs for the recurring decimal block
package frd_pkg;

  // default sizing
  localparam int MaxDenomDef  = 1024;
  localparam int MaxDigitsDef = 64;

  // field widths
  localparam int NumW     = 10;
  localparam int DenW     = 10;
  localparam int CntW     = 7;
  localparam int DigitW   = 4;
  localparam int DigAddrW = 6;

  // remainder times radix, and multiples of the denominator up to nine
  localparam int Radix  = 10;
  localparam int ProdW  = 14;
  localparam int EpochW = 6;

  // input word
  typedef struct packed {
    logic [NumW-1:0] numerator;
    logic [DenW-1:0] denominator;
    logic [CntW-1:0] digit_count;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              repeating;
    logic              last;
    logic              invalid;
  } out_word_t;

  // classified job held in the queue
  typedef struct packed {
    logic            invalid;
    logic [NumW-1:0] numerator;
    logic [DenW-1:0] denominator;
    logic [CntW-1:0] digit_count;
  } job_t;

  // scan outcome handed to the emitter
  typedef struct packed {
    logic            invalid;
    logic            cyclic;
    logic [DenW-1:0] cycle_start;
    logic [DenW-1:0] total;
    logic [CntW-1:0] digit_count;
  } sum_t;

  // digit buffer write port
  typedef struct packed {
    logic                we;
    logic [DigAddrW-1:0] addr;
    logic [DigitW-1:0]   data;
  } dwr_t;

endpackage

[src/frd_front.sv]
// front end: input handshake, fraction check and digit count saturation
module frd_front #(
  parameter int MAX_DENOM  = frd_pkg::MaxDenomDef,
  parameter int MAX_DIGITS = frd_pkg::MaxDigitsDef
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  frd_pkg::in_word_t in_word_i,
  input  logic              clearing_i,
  input  logic              q_full_i,
  output logic              push_o,
  output frd_pkg::job_t     job_o
);

  logic invalid;
  logic drop;

  // hold off while the queue is full or the remainder table is being swept
  assign in_ready_o = !q_full_i && !clearing_i;

  // zero numerator, not a proper fraction, or denominator beyond the table
  assign invalid = (in_word_i.numerator == '0) ||
                   (in_word_i.numerator >= in_word_i.denominator) ||
                   (int'(in_word_i.denominator) > MAX_DENOM);

  // a valid word asking for no digits gives nothing
  assign drop = !invalid && (in_word_i.digit_count == '0);

  assign push_o = in_valid_i && in_ready_o && !drop;

  // classified job
  always_comb begin
    job_o.invalid     = invalid;
    job_o.numerator   = in_word_i.numerator;
    job_o.denominator = in_word_i.denominator;
    if (int'(in_word_i.digit_count) > MAX_DIGITS) begin
      job_o.digit_count = frd_pkg::CntW'(MAX_DIGITS);
    end else begin
      job_o.digit_count = in_word_i.digit_count;
    end
  end

endmodule

[src/frd_queue.sv]
// two-entry job queue between the front end and the scan engine
module frd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  frd_pkg::job_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output frd_pkg::job_t data_o
);

  frd_pkg::job_t slot_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign data_o  = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/frd_scan.sv]
// scan engine: long division with first-seen remainder table and cycle detection
module frd_scan #(
  parameter int MAX_DENOM  = frd_pkg::MaxDenomDef,
  parameter int MAX_DIGITS = frd_pkg::MaxDigitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  frd_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic          emit_busy_i,
  output logic          sum_valid_o,
  input  logic          sum_ready_i,
  output frd_pkg::sum_t sum_o,
  output frd_pkg::dwr_t dwr_o,
  output logic          clearing_o
);

  localparam int DenW     = frd_pkg::DenW;
  localparam int ProdW    = frd_pkg::ProdW;
  localparam int EpochW   = frd_pkg::EpochW;
  localparam int DenLimit = 1 << DenW;
  localparam int TabDepth = (MAX_DENOM < DenLimit) ? MAX_DENOM : DenLimit;
  localparam int TabAw    = $clog2(TabDepth);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PREP  = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [EpochW-1:0] EpochLast  = '1;

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [DenW-1:0]   step;
  } ent_t;

  logic [1:0]        state_q;
  logic [TabAw-1:0]  clr_q;
  logic [EpochW-1:0] epoch_q;

  logic [DenW-1:0]          m_q;
  logic [DenW-1:0]          r_q;
  logic [frd_pkg::CntW-1:0] kreq_q;
  logic [ProdW-1:0]         mult_q [frd_pkg::Radix];
  logic [DenW-1:0]          a_step_q;

  logic                       b_valid_q;
  logic [DenW-1:0]            b_r_q;
  logic [frd_pkg::DigitW-1:0] b_digit_q;
  logic [DenW-1:0]            b_next_q;
  logic [DenW-1:0]            b_step_q;

  logic            byp_q;
  logic [DenW-1:0] byp_step_q;

  logic          sum_valid_q;
  frd_pkg::sum_t sum_q;

  ent_t             tab_mem [TabDepth];
  ent_t             tab_rdata_q;
  logic             tab_we;
  logic             tab_re;
  logic [TabAw-1:0] tab_waddr;
  logic [TabAw-1:0] tab_raddr;
  ent_t             tab_wdata;

  logic [ProdW-1:0]           prod;
  logic [frd_pkg::DigitW-1:0] quot;
  logic [DenW-1:0]            rem;
  logic                       hit;
  logic [DenW-1:0]            hit_step;
  logic                       done;
  logic                       run;

  assign run        = state_q == S_RUN;
  assign clearing_o = state_q == S_CLEAR;
  assign job_pop_o  = (state_q == S_IDLE) && job_valid_i && !sum_valid_q && !emit_busy_i;
  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

  // next digit and remainder: compare ten times r against the stored multiples of m
  always_comb begin
    prod = (ProdW'(r_q) << 3) + (ProdW'(r_q) << 1);
    quot = '0;
    for (int k = 1; k < frd_pkg::Radix; k++) begin
      if (prod >= mult_q[k]) begin
        quot = frd_pkg::DigitW'(k);
      end
    end
    rem = DenW'(prod - mult_q[quot]);
  end

  // lookup outcome for the step in the second stage
  assign hit      = b_valid_q && (byp_q || (tab_rdata_q.epoch == epoch_q));
  assign hit_step = byp_q ? byp_step_q : tab_rdata_q.step;
  assign done     = run && (hit || (b_valid_q && (b_next_q == '0)));

  // table port control
  always_comb begin
    tab_re    = run;
    tab_raddr = r_q[TabAw-1:0];
    if (state_q == S_CLEAR) begin
      tab_we    = 1'b1;
      tab_waddr = clr_q;
      tab_wdata = '{epoch: '0, step: '0};
    end else begin
      tab_we    = run && b_valid_q && !hit;
      tab_waddr = b_r_q[TabAw-1:0];
      tab_wdata = '{epoch: epoch_q, step: b_step_q};
    end
  end

  // digit buffer write for the first digits
  always_comb begin
    dwr_o.we   = run && b_valid_q && !hit && (b_step_q < DenW'(MAX_DIGITS));
    dwr_o.addr = b_step_q[frd_pkg::DigAddrW-1:0];
    dwr_o.data = b_digit_q;
  end

  // remainder table
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rdata_q <= tab_mem[tab_raddr];
    end
  end

  // control state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      epoch_q     <= EpochFirst;
      b_valid_q   <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (sum_valid_q && sum_ready_i) begin
        sum_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (clr_q == TabAw'(TabDepth - 1)) begin
            clr_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (job_pop_o) begin
            if (job_i.invalid) begin
              sum_valid_q <= 1'b1;
            end else begin
              state_q <= S_PREP;
            end
          end
        end
        S_PREP: begin
          b_valid_q <= 1'b0;
          state_q   <= S_RUN;
        end
        S_RUN: begin
          if (done) begin
            b_valid_q   <= 1'b0;
            sum_valid_q <= 1'b1;
            if (epoch_q == EpochLast) begin
              epoch_q <= EpochFirst;
              state_q <= S_CLEAR;
            end else begin
              epoch_q <= epoch_q + 1'b1;
              state_q <= S_IDLE;
            end
          end else begin
            b_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      m_q    <= job_i.denominator;
      r_q    <= job_i.numerator;
      kreq_q <= job_i.digit_count;
    end
    if (state_q == S_PREP) begin
      for (int k = 0; k < frd_pkg::Radix; k++) begin
        mult_q[k] <= ProdW'(ProdW'(m_q) * ProdW'(k));
      end
      a_step_q <= '0;
    end
    if (run) begin
      r_q       <= rem;
      a_step_q  <= a_step_q + 1'b1;
      b_r_q     <= r_q;
      b_digit_q <= quot;
      b_next_q  <= rem;
      b_step_q  <= a_step_q;
    end
    // forward a write that the read in the same cycle cannot see
    byp_q      <= tab_we && tab_re && (tab_waddr == tab_raddr);
    byp_step_q <= b_step_q;
    if (job_pop_o && job_i.invalid) begin
      sum_q <= '{invalid: 1'b1, default: '0};
    end else if (done) begin
      sum_q.invalid     <= 1'b0;
      sum_q.cyclic      <= hit;
      sum_q.cycle_start <= hit ? hit_step : '0;
      sum_q.total       <= hit ? b_step_q : b_step_q + 1'b1;
      sum_q.digit_count <= kreq_q;
    end
  end

  // a repeated remainder was first seen at an earlier step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && hit) |-> (hit_step < b_step_q))
    else $error("cycle start not before the repeating step");

  // the digit buffer is only written while the emitter is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dwr_o.we |-> !emit_busy_i)
    else $error("digit buffer written while emitting");

endmodule

[src/frd_emit.sv]
// emitter: digit buffer, cycle wrap-around and registered result word
module frd_emit #(
  parameter int MAX_DIGITS = frd_pkg::MaxDigitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sum_valid_i,
  output logic               sum_ready_o,
  input  frd_pkg::sum_t      sum_i,
  input  frd_pkg::dwr_t      dwr_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output frd_pkg::out_word_t out_word_o
);

  localparam int DenW  = frd_pkg::DenW;
  localparam int CntW  = frd_pkg::CntW;
  localparam int DigAw = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [frd_pkg::DigitW-1:0] dbuf_mem [MAX_DIGITS];

  logic            active_q;
  logic [CntW-1:0] k_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] cnt_q;
  logic            cyclic_q;
  logic            inv_q;
  logic [DenW-1:0] cs_q;
  logic [DenW-1:0] total_q;

  logic                       rd_valid_q;
  logic [frd_pkg::DigitW-1:0] rd_digit_q;
  logic                       rd_rep_q;
  logic                       rd_last_q;
  logic                       rd_inv_q;

  logic               out_valid_q;
  frd_pkg::out_word_t out_q;

  logic            take;
  logic            adv;
  logic            issue;
  logic            last_now;
  logic            rep_now;
  logic [CntW-1:0] idx_next;
  logic [CntW-1:0] cnt_new;

  assign sum_ready_o = !active_q;
  assign busy_o      = active_q;
  assign take        = sum_valid_i && sum_ready_o;
  assign adv         = rd_valid_q && (!out_valid_q || out_ready_i);
  assign issue       = active_q && (!rd_valid_q || adv);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // digit position flags and buffer index walk, wrapping back to the cycle start
  always_comb begin
    last_now = k_q == (cnt_q - 1'b1);
    rep_now  = cyclic_q && (DenW'(k_q) >= cs_q);
    if (cyclic_q && (DenW'(idx_q) == (total_q - 1'b1))) begin
      idx_next = cs_q[CntW-1:0];
    end else begin
      idx_next = idx_q + 1'b1;
    end
  end

  // number of words for the incoming job
  always_comb begin
    if (sum_i.invalid) begin
      cnt_new = CntW'(1);
    end else if (sum_i.cyclic || (DenW'(sum_i.digit_count) < sum_i.total)) begin
      cnt_new = sum_i.digit_count;
    end else begin
      cnt_new = sum_i.total[CntW-1:0];
    end
  end

  // digit buffer
  always_ff @(posedge clk_i) begin
    if (dwr_i.we) begin
      dbuf_mem[dwr_i.addr[DigAw-1:0]] <= dwr_i.data;
    end
    if (issue) begin
      rd_digit_q <= dbuf_mem[idx_q[DigAw-1:0]];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        active_q <= 1'b1;
      end else if (issue && last_now) begin
        active_q <= 1'b0;
      end
      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (adv) begin
        rd_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // job registers, read stage flags and output word
  always_ff @(posedge clk_i) begin
    if (take) begin
      k_q      <= '0;
      idx_q    <= '0;
      cnt_q    <= cnt_new;
      cyclic_q <= sum_i.cyclic;
      inv_q    <= sum_i.invalid;
      cs_q     <= sum_i.cycle_start;
      total_q  <= sum_i.total;
    end else if (issue) begin
      k_q   <= k_q + 1'b1;
      idx_q <= idx_next;
    end
    if (issue) begin
      rd_rep_q  <= rep_now && !inv_q;
      rd_last_q <= last_now;
      rd_inv_q  <= inv_q;
    end
    if (adv) begin
      out_q.digit     <= rd_inv_q ? '0 : rd_digit_q;
      out_q.repeating <= rd_rep_q;
      out_q.last      <= rd_last_q;
      out_q.invalid   <= rd_inv_q;
    end
  end

  // the word counter stays inside the job's count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (k_q < cnt_q))
    else $error("digit counter past the job's count");

  // an invalid job gives a single zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.invalid) |-> (out_word_o.last && (out_word_o.digit == '0)))
    else $error("invalid word not a single zero digit");

endmodule

[src/fraction_recurring_decimal.sv]
// top level: recurring decimal expansion of a proper fraction, one word per digit
// flow: queue and setup, then one long division step per cycle until a remainder repeats
//   or reaches zero; the emitter then sends the words
// the scan takes no new job until the emitter has drained the last one, as both share
//   the digit buffer
// reset: a sweep clears the remainder table (up to MAX_DENOM entries, 1024 by default), with
//   input held off; it runs again after every 63 valid jobs, when the table epoch wraps
module fraction_recurring_decimal #(
  parameter int MAX_DENOM  = frd_pkg::MaxDenomDef,
  parameter int MAX_DIGITS = frd_pkg::MaxDigitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  frd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output frd_pkg::out_word_t out_word_o
);

  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          clearing;
  logic          emit_busy;
  logic          sum_valid;
  logic          sum_ready;
  frd_pkg::job_t job_in;
  frd_pkg::job_t job_out;
  frd_pkg::sum_t sum;
  frd_pkg::dwr_t dwr;

  // accept and classify
  frd_front #(
    .MAX_DENOM  (MAX_DENOM),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // job queue
  frd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (job_out)
  );

  // long division and cycle detection
  frd_scan #(
    .MAX_DENOM  (MAX_DENOM),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .emit_busy_i (emit_busy),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_o       (sum),
    .dwr_o       (dwr),
    .clearing_o  (clearing)
  );

  // digit output
  frd_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .sum_i       (sum),
    .dwr_i       (dwr),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
